// ===== sv/aist_pkg.sv =====
// ----------------------------------------------------------------------------
// aist_pkg: shared types and constants of the AIG structural hashing table
// Command codes, transfer payloads and the hash table entry format.
// ----------------------------------------------------------------------------
package aist_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int ID_W          = 16;   // holds any node id up to the largest store
  localparam int FID_W         = 10;   // fanin id width of a command
  localparam int LIT_W         = 11;
  localparam int KEY_W         = 2 * LIT_W;
  localparam int CNT_W         = 10;
  localparam int EDGE_W        = 11;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [EDGE_W-1:0] EDGE_MAX = '1;

  typedef enum logic [1:0] {
    CMD_ADD_INPUT  = 2'd0,
    CMD_ADD_AND    = 2'd1,
    CMD_ADD_OUTPUT = 2'd2,
    CMD_READ_FAN   = 2'd3
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t        cmd;
    logic [FID_W-1:0] first_id;
    logic             first_neg;
    logic [FID_W-1:0] second_id;
    logic             second_neg;
  } cmd_item_t;

  typedef struct packed {
    logic [FID_W-1:0]  node_id;
    logic              created;
    logic              full_res;
    logic [CNT_W-1:0]  fanout_count;
    logic [EDGE_W-1:0] edge_total;
    logic [CNT_W-1:0]  input_total;
    logic [CNT_W-1:0]  output_total;
  } res_item_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } hash_entry_t;

endpackage

// ===== sv/aist_cmd_if.sv =====
// ----------------------------------------------------------------------------
// aist_cmd_if: command channel
// Valid/ready channel that carries one command item per transfer.
// ----------------------------------------------------------------------------
interface aist_cmd_if;
  logic                  valid;
  logic                  ready;
  aist_pkg::cmd_item_t   item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== sv/aist_res_if.sv =====
// ----------------------------------------------------------------------------
// aist_res_if: result channel
// Valid/ready channel that carries one result item per transfer.
// ----------------------------------------------------------------------------
interface aist_res_if;
  logic                  valid;
  logic                  ready;
  aist_pkg::res_item_t   item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== sv/aist_hash_mem.sv =====
// ----------------------------------------------------------------------------
// aist_hash_mem: hash table storage
// One write port and one registered read port over the open-addressed table.
// ----------------------------------------------------------------------------
module aist_hash_mem #(
  parameter int HW = 11
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [HW-1:0]         waddr,
  input  aist_pkg::hash_entry_t wdata,
  input  logic [HW-1:0]         raddr,
  output aist_pkg::hash_entry_t rdata
);

  aist_pkg::hash_entry_t mem [2**HW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/aist_fan_mem.sv =====
// ----------------------------------------------------------------------------
// aist_fan_mem: fanout count storage
// Per-node fanout counters with one write port and a registered read port.
// ----------------------------------------------------------------------------
module aist_fan_mem #(
  parameter int NW = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [NW-1:0]              waddr,
  input  logic [aist_pkg::CNT_W-1:0] wdata,
  input  logic [NW-1:0]              raddr,
  output logic [aist_pkg::CNT_W-1:0] rdata
);

  logic [aist_pkg::CNT_W-1:0] mem [2**NW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/and_inverter_graph_strash_table_unit.sv =====
// ----------------------------------------------------------------------------
// and_inverter_graph_strash_table_unit: AIG builder with structural hashing
// Sequencer over an open-addressed hash table and a fanout counter memory.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on cmd_ch and one result leaves on res_ch per command, both
// valid/ready channels; a transfer happens when valid and ready are high at
// a rising edge. Commands add a primary input, add an AND node, add an output
// or read a node's fanout count. AND and output keys are looked up in a hash
// table of 2**($clog2(MAX_NODES)+1) slots with linear probing, so
// duplicates return the existing node id.
// Sequence: an input or a rejected command goes straight to the response
// step, a fanout read passes through a query step, and a lookup repeats a
// probe and a check step per slot; a miss that allocates a node then reads
// and writes the fanout count of its first fanin and, if the second is a
// node, of the second. Probes are bounded by the table's load, at most half
// full. The block takes one command at a time.
// Reset: synchronous rst starts a clearing pass over every hash table address
// and the fanout memory, during which cmd_ch.ready stays low.
// A finished result sits in the output register while the next command is
// worked on; the block only waits when a second result is ready and the
// receiver still stalls.
// ----------------------------------------------------------------------------
module and_inverter_graph_strash_table_unit #(
  parameter int MAX_NODES = aist_pkg::MAX_NODES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  aist_cmd_if.sink   cmd_ch,
  aist_res_if.source res_ch
);

  localparam int NW  = $clog2(MAX_NODES);     // fanout memory address width
  localparam int HW  = NW + 1;                // hash table address width
  localparam int NNW = NW + 1;                // next node counter width
  localparam int CW  = (NNW > aist_pkg::FID_W) ? NNW : aist_pkg::FID_W + 1;
  localparam int NSL = (aist_pkg::KEY_W + HW - 1) / HW;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_PROBE = 10'b0000000100,
    S_CHECK = 10'b0000001000,
    S_F0RD  = 10'b0000010000,
    S_F0WR  = 10'b0000100000,
    S_F1RD  = 10'b0001000000,
    S_F1WR  = 10'b0010000000,
    S_FQRY  = 10'b0100000000,
    S_RESP  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // Command context held while the sequencer works.
  aist_pkg::cmd_code_t             cur_cmd;
  logic [aist_pkg::FID_W-1:0]      id0, id1;
  logic [aist_pkg::KEY_W-1:0]      key;
  logic [HW-1:0]                   slot;
  logic [HW-1:0]                   clr_addr;

  // Graph counters.
  logic [NNW-1:0]                  next_node;
  logic [aist_pkg::EDGE_W-1:0]     edge_cnt;
  logic [aist_pkg::CNT_W-1:0]      in_cnt, out_cnt;

  // Pending result fields.
  logic [aist_pkg::ID_W-1:0]       node_res;
  logic                            created, full;

  aist_pkg::res_item_t             res_item;
  logic                            res_valid;

  // Decode of the incoming command.
  logic                            accept;
  logic                            swap;
  logic                            fanin_ok;
  logic [aist_pkg::FID_W-1:0]      in_id0, in_id1, lit_id1;
  logic                            in_n0, in_n1, lit_n1;
  logic [aist_pkg::KEY_W-1:0]      in_key;
  logic [NSL*HW-1:0]               key_pad;
  logic [HW-1:0]                   in_slot;

  // Memory ports.
  logic                            h_we;
  logic [HW-1:0]                   h_waddr;
  aist_pkg::hash_entry_t           h_wdata, h_rdata;
  logic                            f_we;
  logic [NW-1:0]                   f_waddr, f_raddr;
  logic [aist_pkg::CNT_W-1:0]      f_wdata, f_rdata;

  logic                            hit;
  logic                            has_second;
  logic                            qry_ok;
  logic                            out_free;

  assign accept     = cmd_ch.valid && cmd_ch.ready;
  assign cmd_ch.ready = (state == S_IDLE);
  assign res_ch.valid = res_valid;
  assign res_ch.item  = res_item;

  // Ordering of the fanins and key construction.
  always_comb begin
    lit_id1  = (cmd_ch.item.cmd == aist_pkg::CMD_ADD_OUTPUT) ? '0 : cmd_ch.item.second_id;
    lit_n1   = (cmd_ch.item.cmd == aist_pkg::CMD_ADD_OUTPUT) ? 1'b0 : cmd_ch.item.second_neg;
    swap     = (lit_id1 != '0) && (lit_id1 < cmd_ch.item.first_id);
    in_id0   = swap ? lit_id1 : cmd_ch.item.first_id;
    in_n0    = swap ? lit_n1 : cmd_ch.item.first_neg;
    in_id1   = swap ? cmd_ch.item.first_id : lit_id1;
    in_n1    = swap ? cmd_ch.item.first_neg : lit_n1;
    in_key   = {in_id0, in_n0, in_id1, in_n1};
    fanin_ok = (cmd_ch.item.first_id >= aist_pkg::FID_W'(2))
            && (CW'(cmd_ch.item.first_id) < CW'(next_node))
            && (CW'(lit_id1) < CW'(next_node));
  end

  // Slot hash: XOR fold of the key into the table address width.
  always_comb begin
    key_pad = (NSL*HW)'(in_key);
    in_slot = '0;
    for (int i = 0; i < NSL; i++) begin
      in_slot = in_slot ^ key_pad[i*HW +: HW];
    end
  end

  assign hit        = h_rdata.valid && (h_rdata.key == key);
  assign has_second = (id1 >= aist_pkg::FID_W'(2));
  assign qry_ok     = (CW'(id0) < CW'(MAX_NODES));
  assign out_free   = !res_valid || res_ch.ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_ch.item.cmd)
            aist_pkg::CMD_ADD_INPUT:  state_next = S_RESP;
            aist_pkg::CMD_READ_FAN:   state_next = S_FQRY;
            aist_pkg::CMD_ADD_AND,
            aist_pkg::CMD_ADD_OUTPUT: state_next = fanin_ok ? S_PROBE : S_RESP;
            default:                  state_next = S_RESP;
          endcase
        end
      end
      S_PROBE: state_next = S_CHECK;
      S_CHECK: begin
        priority if (hit)                         state_next = S_RESP;
        else if (h_rdata.valid)                   state_next = S_PROBE;
        else if (CW'(next_node) >= CW'(MAX_NODES)) state_next = S_RESP;
        else                                      state_next = S_F0RD;
      end
      S_F0RD:  state_next = S_F0WR;
      S_F0WR:  state_next = has_second ? S_F1RD : S_RESP;
      S_F1RD:  state_next = S_F1WR;
      S_F1WR:  state_next = S_RESP;
      S_FQRY:  state_next = S_RESP;
      S_RESP:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Memory port control.
  always_comb begin
    h_we          = 1'b0;
    h_waddr       = slot;
    h_wdata.valid = 1'b1;
    h_wdata.key   = key;
    h_wdata.id    = aist_pkg::ID_W'(next_node);
    f_we          = 1'b0;
    f_waddr       = NW'(id0);
    f_raddr       = (state == S_F1RD) ? NW'(id1) : NW'(id0);
    f_wdata       = (f_rdata == aist_pkg::CNT_MAX) ? f_rdata : f_rdata + 1'b1;
    if (state == S_CLEAR) begin
      h_we    = 1'b1;
      h_waddr = clr_addr;
      h_wdata = '0;
      f_we    = 1'b1;
      f_waddr = clr_addr[NW-1:0];
      f_wdata = '0;
    end else if (state == S_CHECK) begin
      h_we = !h_rdata.valid && (CW'(next_node) < CW'(MAX_NODES));
    end else if (state == S_F0WR) begin
      f_we = 1'b1;
    end else if (state == S_F1WR) begin
      f_we    = 1'b1;
      f_waddr = NW'(id1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      next_node <= NNW'(2);
      edge_cnt  <= '0;
      in_cnt    <= '0;
      out_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      // A new result is loaded as the old one leaves or into an empty register.
      if (state == S_RESP && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ch.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: clr_addr <= clr_addr + 1'b1;
        S_IDLE: begin
          if (accept) begin
            cur_cmd  <= cmd_ch.item.cmd;
            // A fanout query keeps the queried id in its original position.
            id0      <= (cmd_ch.item.cmd == aist_pkg::CMD_READ_FAN) ?
                        cmd_ch.item.first_id : in_id0;
            id1      <= in_id1;
            key      <= in_key;
            slot     <= in_slot;
            if (cmd_ch.item.cmd == aist_pkg::CMD_ADD_INPUT &&
                CW'(next_node) < CW'(MAX_NODES)) begin
              node_res  <= aist_pkg::ID_W'(next_node);
              created   <= 1'b1;
              full      <= 1'b0;
              next_node <= next_node + 1'b1;
              if (in_cnt != aist_pkg::CNT_MAX) in_cnt <= in_cnt + 1'b1;
            end else begin
              node_res <= '0;
              created  <= 1'b0;
              full     <= (cmd_ch.item.cmd == aist_pkg::CMD_ADD_INPUT);
            end
          end
        end
        S_CHECK: begin
          priority if (hit) begin
            node_res <= h_rdata.id;
          end else if (h_rdata.valid) begin
            slot <= slot + 1'b1;
          end else if (CW'(next_node) >= CW'(MAX_NODES)) begin
            full <= 1'b1;
          end else begin
            node_res  <= aist_pkg::ID_W'(next_node);
            created   <= 1'b1;
            next_node <= next_node + 1'b1;
            if (cur_cmd == aist_pkg::CMD_ADD_OUTPUT && out_cnt != aist_pkg::CNT_MAX) begin
              out_cnt <= out_cnt + 1'b1;
            end
          end
        end
        S_F0WR, S_F1WR: begin
          if (edge_cnt != aist_pkg::EDGE_MAX) edge_cnt <= edge_cnt + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register payload, loaded when the result is handed over.
  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      res_item.node_id      <= aist_pkg::FID_W'(node_res);
      res_item.created      <= created;
      res_item.full_res     <= full;
      res_item.fanout_count <= (cur_cmd == aist_pkg::CMD_READ_FAN && qry_ok) ? f_rdata : '0;
      res_item.edge_total   <= edge_cnt;
      res_item.input_total  <= in_cnt;
      res_item.output_total <= out_cnt;
    end
  end

  aist_hash_mem #(.HW(HW)) u_hash (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (slot),
    .rdata (h_rdata)
  );

  aist_fan_mem #(.NW(NW)) u_fan (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

`ifndef NO_ASSERTIONS
  a_res_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(res_ch.valid) |-> $past(state == S_RESP))
    else $error("result raised outside the response step");

  a_next_node_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(next_node) <= CW'(MAX_NODES))
    else $error("node allocation ran past the store size");

  a_created_not_full: assert property (@(posedge clk) disable iff (rst)
    res_ch.valid |-> !(res_ch.item.created && res_ch.item.full_res))
    else $error("result both created and full");

  a_no_accept_clear: assert property (@(posedge clk)
    (state == S_CLEAR) |-> !cmd_ch.ready)
    else $error("command accepted during clearing pass");
`endif

endmodule
